### hw/rtl/quadratic_least_squares_fit_defines.svh
// Assertion macros shared by the fit block. Each use names a label, a property
// and a message. The clock is clk and the active-low reset rst_n of the module.
`ifndef QUADRATIC_LEAST_SQUARES_FIT_DEFINES_SVH
`define QUADRATIC_LEAST_SQUARES_FIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QLSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QLSF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define QLSF_ASSERT(lbl, prop, msg)
`define QLSF_NEVER(lbl, cond, msg)
`endif

`endif

### hw/rtl/qlsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlsf_pkg
// Types, widths and the solver program of the quadratic least-squares fit.
// ----------------------------------------------------------------------------
package qlsf_pkg;

  localparam int X_W       = 12;
  localparam int Y_W       = 16;
  localparam int CNT_W     = 11;
  localparam int SX_W      = 22;
  localparam int SX2_W     = 34;
  localparam int SX3_W     = 44;
  localparam int SX4_W     = 56;
  localparam int SY_W      = 26;
  localparam int SXY_W     = 38;
  localparam int SX2Y_W    = 48;
  localparam int WIDE_W    = 192;
  localparam int OPB_W     = 64;
  localparam int FRAC_W    = 32;
  localparam int THR_W     = 32;
  localparam int COEF_W    = 64;
  localparam int PC_W      = 5;
  localparam int STEP_W    = 8;
  localparam int MAX_POINTS_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [PC_W-1:0] PC_LAST = 5'd23;
  localparam logic [THR_W-1:0] THR_RESET = 32'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_SING  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic signed [Y_W-1:0] y_value;
    logic                  include_req;
    logic                  last_point;
  } qlsf_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] const_term;
    logic signed [COEF_W-1:0] linear_term;
    logic signed [COEF_W-1:0] quad_term;
    logic [1:0]               status;
  } qlsf_out_t;

  typedef struct packed {
    logic                     short_run;
    logic [CNT_W-1:0]         count;
    logic signed [SX_W-1:0]   sum_x;
    logic signed [SX2_W-1:0]  sum_x_sq;
    logic signed [SX3_W-1:0]  sum_x_cube;
    logic signed [SX4_W-1:0]  sum_x_fourth;
    logic signed [SY_W-1:0]   sum_y;
    logic signed [SXY_W-1:0]  sum_xy;
    logic signed [SX2Y_W-1:0] sum_x_sq_y;
  } qlsf_snap_t;

  typedef enum logic [2:0] {
    SEL_S0, SEL_SX, SEL_SX2, SEL_SX3, SEL_SX4, SEL_SY, SEL_SXY, SEL_SX2Y
  } sel_t;

  typedef enum logic [2:0] {
    W_C00, W_C01, W_C02, W_C11, W_C12, W_C22, W_DET
  } widx_t;

  typedef enum logic [1:0] {
    FIN_NONE, FIN_CHECK, FIN_DIV
  } fin_t;

  typedef struct packed {
    logic  a_wide;
    sel_t  a_sum;
    widx_t a_reg;
    sel_t  b_sum;
    logic  clr;
    logic  sub;
    logic  wr;
    widx_t dst;
    fin_t  fin;
  } mop_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL_START, BK_MUL, BK_CHECK, BK_DIV_LOAD, BK_DIV, BK_SAT
  } bk_state_t;

  function automatic mop_t mop_rom(input logic [PC_W-1:0] pc);
    mop_t m;
    m = '{1'b0, SEL_S0, W_C00, SEL_S0, 1'b1, 1'b0, 1'b0, W_C00, FIN_NONE};
    case (pc)
      5'd0:  m = '{1'b0, SEL_SX2, W_C00, SEL_SX4, 1'b1, 1'b0, 1'b0, W_C00, FIN_NONE};
      5'd1:  m = '{1'b0, SEL_SX3, W_C00, SEL_SX3, 1'b0, 1'b1, 1'b1, W_C00, FIN_NONE};
      5'd2:  m = '{1'b0, SEL_SX2, W_C00, SEL_SX3, 1'b1, 1'b0, 1'b0, W_C01, FIN_NONE};
      5'd3:  m = '{1'b0, SEL_SX,  W_C00, SEL_SX4, 1'b0, 1'b1, 1'b1, W_C01, FIN_NONE};
      5'd4:  m = '{1'b0, SEL_SX,  W_C00, SEL_SX3, 1'b1, 1'b0, 1'b0, W_C02, FIN_NONE};
      5'd5:  m = '{1'b0, SEL_SX2, W_C00, SEL_SX2, 1'b0, 1'b1, 1'b1, W_C02, FIN_NONE};
      5'd6:  m = '{1'b0, SEL_S0,  W_C00, SEL_SX4, 1'b1, 1'b0, 1'b0, W_C11, FIN_NONE};
      5'd7:  m = '{1'b0, SEL_SX2, W_C00, SEL_SX2, 1'b0, 1'b1, 1'b1, W_C11, FIN_NONE};
      5'd8:  m = '{1'b0, SEL_SX2, W_C00, SEL_SX,  1'b1, 1'b0, 1'b0, W_C12, FIN_NONE};
      5'd9:  m = '{1'b0, SEL_S0,  W_C00, SEL_SX3, 1'b0, 1'b1, 1'b1, W_C12, FIN_NONE};
      5'd10: m = '{1'b0, SEL_S0,  W_C00, SEL_SX2, 1'b1, 1'b0, 1'b0, W_C22, FIN_NONE};
      5'd11: m = '{1'b0, SEL_SX,  W_C00, SEL_SX,  1'b0, 1'b1, 1'b1, W_C22, FIN_NONE};
      5'd12: m = '{1'b1, SEL_S0,  W_C00, SEL_S0,  1'b1, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd13: m = '{1'b1, SEL_S0,  W_C01, SEL_SX,  1'b0, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd14: m = '{1'b1, SEL_S0,  W_C02, SEL_SX2, 1'b0, 1'b0, 1'b1, W_DET, FIN_CHECK};
      5'd15: m = '{1'b1, SEL_S0,  W_C00, SEL_SY,  1'b1, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd16: m = '{1'b1, SEL_S0,  W_C01, SEL_SXY, 1'b0, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd17: m = '{1'b1, SEL_S0,  W_C02, SEL_SX2Y, 1'b0, 1'b0, 1'b0, W_DET, FIN_DIV};
      5'd18: m = '{1'b1, SEL_S0,  W_C01, SEL_SY,  1'b1, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd19: m = '{1'b1, SEL_S0,  W_C11, SEL_SXY, 1'b0, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd20: m = '{1'b1, SEL_S0,  W_C12, SEL_SX2Y, 1'b0, 1'b0, 1'b0, W_DET, FIN_DIV};
      5'd21: m = '{1'b1, SEL_S0,  W_C02, SEL_SY,  1'b1, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd22: m = '{1'b1, SEL_S0,  W_C12, SEL_SXY, 1'b0, 1'b0, 1'b0, W_DET, FIN_NONE};
      5'd23: m = '{1'b1, SEL_S0,  W_C22, SEL_SX2Y, 1'b0, 1'b0, 1'b0, W_DET, FIN_DIV};
      default: m = '{1'b0, SEL_S0, W_C00, SEL_S0, 1'b1, 1'b0, 1'b0, W_C00, FIN_NONE};
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/qlsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlsf_front
// Takes points, forms powers in a short pipeline and keeps the running sums.
// ----------------------------------------------------------------------------
module qlsf_front #(
  parameter int MAX_POINTS  = qlsf_pkg::MAX_POINTS_DEF,
  parameter int QUEUE_DEPTH = qlsf_pkg::QUEUE_DEPTH_DEF,
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  qlsf_pkg::qlsf_in_t   in_data,
  input  logic [LVL_W-1:0]     q_level,
  output logic                 push,
  output qlsf_pkg::qlsf_snap_t push_data
);
  import qlsf_pkg::*;

  typedef struct packed {
    logic                  v;
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  inc;
    logic                  last;
    logic                  short_run;
    logic [CNT_W-1:0]      count;
  } p1_t;

  typedef struct packed {
    logic                  v;
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic signed [23:0]    x2;
    logic signed [27:0]    yx;
    logic                  inc;
    logic                  last;
    logic                  short_run;
    logic [CNT_W-1:0]      count;
  } p2_t;

  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, seen_r, seen_nxt, seen_inc, cnt_inc;
  qlsf_snap_t sums_r, sums_nxt, sums_add;
  logic accept, inc_eff;
  logic [LVL_W:0] pending;
  logic signed [33:0] x3;
  logic signed [45:0] x4;
  logic signed [39:0] yx2;

  assign pending = (LVL_W + 1)'(q_level) + (LVL_W + 1)'(p1_r.v & p1_r.last)
                 + (LVL_W + 1)'(p2_r.v & p2_r.last);
  assign busy    = pending >= (LVL_W + 1)'(QUEUE_DEPTH);
  assign accept  = start && !busy;

  assign inc_eff  = in_data.include_req && (cnt_r < CNT_W'(MAX_POINTS));
  assign cnt_inc  = cnt_r + CNT_W'(inc_eff);
  assign seen_inc = (seen_r < CNT_W'(MAX_POINTS)) ? seen_r + 1'b1 : seen_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    p1_nxt   = p1_r;
    p1_nxt.v = accept;
    if (accept) begin
      cnt_nxt          = in_data.last_point ? '0 : cnt_inc;
      seen_nxt         = in_data.last_point ? '0 : seen_inc;
      p1_nxt.x         = in_data.x_value;
      p1_nxt.y         = in_data.y_value;
      p1_nxt.inc       = inc_eff;
      p1_nxt.last      = in_data.last_point;
      p1_nxt.short_run = seen_inc < CNT_W'(3);
      p1_nxt.count     = cnt_inc;
    end
  end

  always_comb begin
    p2_nxt           = p2_r;
    p2_nxt.v         = p1_r.v;
    p2_nxt.x         = p1_r.x;
    p2_nxt.y         = p1_r.y;
    p2_nxt.x2        = 24'(p1_r.x) * 24'(p1_r.x);
    p2_nxt.yx        = 28'(p1_r.y) * 28'(p1_r.x);
    p2_nxt.inc       = p1_r.inc;
    p2_nxt.last      = p1_r.last;
    p2_nxt.short_run = p1_r.short_run;
    p2_nxt.count     = p1_r.count;
  end

  assign x3  = 34'(p2_r.x2) * 34'(p2_r.x);
  assign x4  = 46'(p2_r.x2) * 46'(p2_r.x2);
  assign yx2 = 40'(p2_r.y) * 40'(p2_r.x2);

  always_comb begin
    sums_add              = sums_r;
    sums_add.short_run    = p2_r.short_run;
    sums_add.count        = p2_r.count;
    if (p2_r.inc) begin
      sums_add.sum_x        = sums_r.sum_x + SX_W'(p2_r.x);
      sums_add.sum_x_sq     = sums_r.sum_x_sq + SX2_W'(p2_r.x2);
      sums_add.sum_x_cube   = sums_r.sum_x_cube + SX3_W'(x3);
      sums_add.sum_x_fourth = sums_r.sum_x_fourth + SX4_W'(x4);
      sums_add.sum_y        = sums_r.sum_y + SY_W'(p2_r.y);
      sums_add.sum_xy       = sums_r.sum_xy + SXY_W'(p2_r.yx);
      sums_add.sum_x_sq_y   = sums_r.sum_x_sq_y + SX2Y_W'(yx2);
    end
    sums_nxt = sums_r;
    if (p2_r.v) begin
      sums_nxt = p2_r.last ? '0 : sums_add;
    end
  end

  assign push      = p2_r.v && p2_r.last;
  assign push_data = sums_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seen_r <= '0;
      p1_r   <= '0;
      p2_r   <= '0;
      sums_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      seen_r <= seen_nxt;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      sums_r <= sums_nxt;
    end
  end

endmodule

### hw/rtl/qlsf_queue.sv
`timescale 1ns / 1ps
`include "quadratic_least_squares_fit_defines.svh"
// ----------------------------------------------------------------------------
// qlsf_queue
// Short queue of finished run sums between the front and the solver.
// ----------------------------------------------------------------------------
module qlsf_queue #(
  parameter int DEPTH = qlsf_pkg::QUEUE_DEPTH_DEF,
  localparam int LVL_W = $clog2(DEPTH + 1),
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  qlsf_pkg::qlsf_snap_t push_data_i,
  input  logic                 pop_i,
  output qlsf_pkg::qlsf_snap_t head_o,
  output logic                 empty_o,
  output logic [LVL_W-1:0]     level_o
);
  import qlsf_pkg::*;

  qlsf_snap_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = level_r == '0;
  assign level_o = level_r;
  assign head_o  = mem_r[rd_r];

  always_comb begin
    wr_nxt    = push_i ? bump(wr_r) : wr_r;
    rd_nxt    = pop_i ? bump(rd_r) : rd_r;
    level_nxt = level_r + LVL_W'(push_i) - LVL_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  `QLSF_NEVER(a_overflow, push_i && !pop_i && (level_r == LVL_W'(DEPTH)), "queue overflow")
  `QLSF_NEVER(a_underflow, pop_i && empty_o, "queue pop while empty")
  `QLSF_ASSERT(a_level_up, push_i && !pop_i |=> level_r == $past(level_r) + 1'b1, "level")
endmodule

### hw/rtl/qlsf_back.sv
`timescale 1ns / 1ps
`include "quadratic_least_squares_fit_defines.svh"
// ----------------------------------------------------------------------------
// qlsf_back
// Solver: cofactors, determinant and numerators by shift-add multiplies,
// then restoring division and saturation of each coefficient.
// ----------------------------------------------------------------------------
module qlsf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         empty_i,
  input  qlsf_pkg::qlsf_snap_t         head_i,
  output logic                         pop_o,
  input  logic [qlsf_pkg::THR_W-1:0]   det_threshold,
  output logic                         out_valid,
  output qlsf_pkg::qlsf_out_t          out_data
);
  import qlsf_pkg::*;

  bk_state_t state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic signed [WIDE_W-1:0] wide_r [7];
  logic [WIDE_W-1:0] acc_r, acc_nxt, ash_r, ash_nxt, dmag_r, dmag_nxt;
  logic [WIDE_W-1:0] nq_r, nq_nxt, rem_r, rem_nxt;
  logic [OPB_W-1:0]  b_r, b_nxt;
  logic              sub_r, sub_nxt, dneg_r, dneg_nxt, cneg_r, cneg_nxt;
  logic              wr_r, wr_nxt;
  widx_t             dst_r, dst_nxt;
  fin_t              fin_r, fin_nxt;
  logic [1:0]        cidx_r, cidx_nxt;
  logic [COEF_W-1:0] c0_r, c0_nxt, c1_r, c1_nxt;
  qlsf_snap_t        run_r, run_nxt;
  qlsf_out_t         out_r, out_nxt;
  logic              outv_r, outv_nxt;

  mop_t              mop;
  logic [WIDE_W-1:0] a_val, term, det, det_mag, num_mag;
  logic              neg_term, mul_done, div_done, singular, ge;
  logic [WIDE_W:0]   rem_sh;
  logic [COEF_W-1:0] coef;

  function automatic logic signed [OPB_W-1:0] sum_sel(input sel_t s, input qlsf_snap_t p);
    logic signed [OPB_W-1:0] v;
    case (s)
      SEL_S0:   v = OPB_W'(p.count);
      SEL_SX:   v = OPB_W'(p.sum_x);
      SEL_SX2:  v = OPB_W'(p.sum_x_sq);
      SEL_SX3:  v = OPB_W'(p.sum_x_cube);
      SEL_SX4:  v = OPB_W'(p.sum_x_fourth);
      SEL_SY:   v = OPB_W'(p.sum_y);
      SEL_SXY:  v = OPB_W'(p.sum_xy);
      SEL_SX2Y: v = OPB_W'(p.sum_x_sq_y);
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign mop      = mop_rom(pc_r);
  assign a_val    = mop.a_wide ? wide_r[mop.a_reg] : WIDE_W'(sum_sel(mop.a_sum, run_r));
  assign mul_done = step_r == STEP_W'(OPB_W - 1);
  assign div_done = step_r == STEP_W'(WIDE_W - 1);
  assign neg_term = mul_done ^ sub_r;
  assign term     = b_r[0] ? (neg_term ? ~ash_r : ash_r) : '0;

  assign det      = wide_r[W_DET];
  assign det_mag  = det[WIDE_W-1] ? -det : det;
  assign singular = (det == '0) ||
                    ((det_mag[WIDE_W-1:THR_W] == '0) && (det_mag[THR_W-1:0] < det_threshold));
  assign num_mag  = acc_r[WIDE_W-1] ? -acc_r : acc_r;

  assign rem_sh = {rem_r, nq_r[WIDE_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag_r};

  always_comb begin
    if (nq_r[WIDE_W-1:COEF_W] != '0) begin
      coef = cneg_r ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else if (!cneg_r) begin
      coef = nq_r[COEF_W-1] ? {1'b0, {(COEF_W-1){1'b1}}} : nq_r[COEF_W-1:0];
    end else if (nq_r[COEF_W-1] && (nq_r[COEF_W-2:0] != '0)) begin
      coef = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      coef = -nq_r[COEF_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!empty_i && !head_i.short_run) begin
          state_nxt = BK_MUL_START;
        end
      end
      BK_MUL_START: state_nxt = BK_MUL;
      BK_MUL: begin
        if (mul_done) begin
          case (fin_r)
            FIN_CHECK: state_nxt = BK_CHECK;
            FIN_DIV:   state_nxt = BK_DIV_LOAD;
            default:   state_nxt = BK_MUL_START;
          endcase
        end
      end
      BK_CHECK:    state_nxt = singular ? BK_IDLE : BK_MUL_START;
      BK_DIV_LOAD: state_nxt = BK_DIV;
      BK_DIV:      state_nxt = div_done ? BK_SAT : BK_DIV;
      BK_SAT:      state_nxt = (pc_r == PC_LAST) ? BK_IDLE : BK_MUL_START;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    b_nxt    = b_r;
    sub_nxt  = sub_r;
    wr_nxt   = wr_r;
    dst_nxt  = dst_r;
    fin_nxt  = fin_r;
    dmag_nxt = dmag_r;
    dneg_nxt = dneg_r;
    cneg_nxt = cneg_r;
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    cidx_nxt = cidx_r;
    c0_nxt   = c0_r;
    c1_nxt   = c1_r;
    run_nxt  = run_r;
    out_nxt  = out_r;
    outv_nxt = 1'b0;
    pop_o    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          run_nxt  = head_i;
          pc_nxt   = '0;
          cidx_nxt = '0;
          if (head_i.short_run) begin
            outv_nxt = 1'b1;
            out_nxt  = '{'0, '0, '0, ST_SHORT};
          end
        end
      end
      BK_MUL_START: begin
        step_nxt = '0;
        ash_nxt  = a_val;
        b_nxt    = sum_sel(mop.b_sum, run_r);
        acc_nxt  = mop.clr ? '0 : acc_r;
        sub_nxt  = mop.sub;
        wr_nxt   = mop.wr;
        dst_nxt  = mop.dst;
        fin_nxt  = mop.fin;
      end
      BK_MUL: begin
        acc_nxt  = acc_r + term + WIDE_W'(b_r[0] & neg_term);
        ash_nxt  = ash_r << 1;
        b_nxt    = b_r >> 1;
        step_nxt = step_r + 1'b1;
        if (mul_done && (fin_r == FIN_NONE)) begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      BK_CHECK: begin
        dmag_nxt = det_mag;
        dneg_nxt = det[WIDE_W-1];
        pc_nxt   = pc_r + 1'b1;
        if (singular) begin
          outv_nxt = 1'b1;
          out_nxt  = '{'0, '0, '0, ST_SING};
        end
      end
      BK_DIV_LOAD: begin
        nq_nxt   = num_mag << FRAC_W;
        rem_nxt  = '0;
        cneg_nxt = acc_r[WIDE_W-1] ^ dneg_r;
        step_nxt = '0;
      end
      BK_DIV: begin
        rem_nxt  = ge ? WIDE_W'(rem_sh - {1'b0, dmag_r}) : rem_sh[WIDE_W-1:0];
        nq_nxt   = {nq_r[WIDE_W-2:0], ge};
        step_nxt = step_r + 1'b1;
      end
      BK_SAT: begin
        cidx_nxt = cidx_r + 1'b1;
        pc_nxt   = pc_r + 1'b1;
        if (cidx_r == 2'd0) begin
          c0_nxt = coef;
        end else if (cidx_r == 2'd1) begin
          c1_nxt = coef;
        end
        if (pc_r == PC_LAST) begin
          outv_nxt = 1'b1;
          out_nxt  = '{c0_r, c1_r, coef, ST_OK};
        end
      end
      default: begin
        outv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == BK_MUL) && mul_done && wr_r) begin
      wide_r[dst_r] <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    ash_r  <= ash_nxt;
    b_r    <= b_nxt;
    sub_r  <= sub_nxt;
    wr_r   <= wr_nxt;
    dst_r  <= dst_nxt;
    fin_r  <= fin_nxt;
    dmag_r <= dmag_nxt;
    dneg_r <= dneg_nxt;
    cneg_r <= cneg_nxt;
    nq_r   <= nq_nxt;
    rem_r  <= rem_nxt;
    c0_r   <= c0_nxt;
    c1_r   <= c1_nxt;
    run_r  <= run_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pc_r    <= '0;
      step_r  <= '0;
      cidx_r  <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      step_r  <= step_nxt;
      cidx_r  <= cidx_nxt;
      outv_r  <= outv_nxt;
    end
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;

  `QLSF_ASSERT(a_err_zero, out_valid && (out_data.status != ST_OK) |-> (out_data.const_term == '0) && (out_data.linear_term == '0) && (out_data.quad_term == '0), "error beat carries coefficients")
  `QLSF_ASSERT(a_pc_range, (state_r != BK_IDLE) |-> (pc_r <= PC_LAST), "program counter out of range")
  `QLSF_ASSERT(a_short_fast, (state_r == BK_IDLE) && !empty_i && head_i.short_run |=> out_valid && (out_data.status == ST_SHORT), "short run not reported")
endmodule

### hw/rtl/quadratic_least_squares_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Least-squares fit of y = c + b*x + a*x^2 over runs of integer points.
// ----------------------------------------------------------------------------
// Points are taken one per clock while busy is low; each included point adds
// to the power sums after a three-stage pipeline. The point marked last hands
// the run sums to a two-entry queue, and the solver works them off one run at
// a time. A run of at least three points takes the solver up to 24 shift-add
// multiplies on one 192-bit adder and three restoring divisions, each
// division with a load step before it and a saturation step after it.
// A short run is reported the cycle after the solver takes it; a singular
// matrix once the determinant has been formed and checked. busy rises only
// while two finished runs are waiting or in flight. Each result beat is
// shown for one cycle with out_valid and cannot be held off by the
// receiver. There is no clearing pass after reset.
module quadratic_least_squares_fit #(
  parameter int MAX_POINTS  = qlsf_pkg::MAX_POINTS_DEF,
  parameter int QUEUE_DEPTH = qlsf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  qlsf_pkg::qlsf_in_t         in_data,
  output logic                       out_valid,
  output qlsf_pkg::qlsf_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [qlsf_pkg::THR_W-1:0] cfg_wdata
);
  import qlsf_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [THR_W-1:0] thr_r;
  logic             push, pop, empty;
  qlsf_snap_t       push_data, head;
  logic [LVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  qlsf_front #(
    .MAX_POINTS  (MAX_POINTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .q_level   (level),
    .push      (push),
    .push_data (push_data)
  );

  qlsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .level_o     (level)
  );

  qlsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .det_threshold (thr_r),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

endmodule
